/* hdl/lfu_cache_table_top_macros.svh */
// Assertion macros for the LFU cache table checker.
// Needs nothing else; included by the checker file.
`ifndef LFU_CACHE_TABLE_TOP_MACROS_SVH
`define LFU_CACHE_TABLE_TOP_MACROS_SVH

// Clocked assertion with synchronous reset disable and a fixed message.
`define LFCT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lfct assertion failed");

// Same, with a caller supplied message.
`define LFCT_ASSERT_MSG(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`endif

/* hdl/lfct_pkg.sv */
// Shared types and constants of the LFU cache table.
// No dependencies; used by the interfaces, the compare unit and the top level.
package lfct_pkg;

  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W      = $clog2(CAPACITY + 1);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [OCC_W-1:0]        occ_t;
  typedef logic [CAP_W-1:0]        cap_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic   valid;
    key_t   key;
    count_t cnt;
    idx_t   rank;
  } cand_t;

  typedef struct packed {
    logic   found;
    count_t cnt;
    idx_t   rank;
  } best_t;

  typedef struct packed {
    logic hit;
    logic better;
  } cmp_res_t;

endpackage

/* hdl/lfct_if.sv */
// Request, response and configuration channel interfaces of the LFU cache table.
// Depends on lfct_pkg.
interface lfct_req_if;
  import lfct_pkg::*;
  logic valid;
  logic ready;
  logic cmd;
  key_t lookup_key;
  val_t new_value;
  modport source (output valid, output cmd, output lookup_key, output new_value,
                  input ready);
  modport sink   (input valid, input cmd, input lookup_key, input new_value,
                  output ready);
endinterface

interface lfct_rsp_if;
  import lfct_pkg::*;
  logic valid;
  logic ready;
  logic found;
  val_t read_value;
  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

interface lfct_cfg_if;
  import lfct_pkg::*;
  logic valid;
  logic ready;
  cap_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/lfct_cmp.sv */
// Shared compare unit: key match and eviction order for one table entry.
// Depends on lfct_pkg.
module lfct_cmp (
  input  lfct_pkg::key_t     lookup_key,
  input  lfct_pkg::cand_t    cand,
  input  lfct_pkg::best_t    best,
  output lfct_pkg::cmp_res_t res
);
  import lfct_pkg::*;

  always_comb begin
    res.hit    = cand.valid && (cand.key == lookup_key);
    res.better = cand.valid &&
                 (!best.found || (cand.cnt < best.cnt) ||
                  ((cand.cnt == best.cnt) && (cand.rank > best.rank)));
  end

endmodule

/* hdl/lfu_cache_table_top.sv */
// LFU cache table with LRU tie break: a 16-step scan through one compare unit.
// Request to response, a miss get passes through S_SCAN and S_DONE, a hit or plain insert
// adds S_TOUCH or S_INSERT, and a put that evicts adds S_EVICT then S_INSERT. One request at a
// time: the next is taken only after the scan through the shared lfct_cmp unit and once S_DONE loads the response.
// Synchronous reset clears the valid table and occupancy at once, capacity 16.
// Depends on lfct_pkg, lfct_if and lfct_cmp.
module lfu_cache_table_top (
  input  logic       clk,
  input  logic       rst,
  lfct_req_if.sink   req,
  lfct_rsp_if.source rsp,
  lfct_cfg_if.sink   cfg
);
  import lfct_pkg::*;

  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_TOUCH  = 6'b000100,
    S_EVICT  = 6'b001000,
    S_INSERT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  idx_t   idx;
  cap_t   capacity;
  occ_t   occ;

  logic   entry_valid [CAPACITY];
  key_t   entry_key   [CAPACITY];
  val_t   entry_value [CAPACITY];
  count_t use_count   [CAPACITY];
  idx_t   recency_rank[CAPACITY];

  logic   cmd_q;
  key_t   key_q;
  val_t   val_q;
  logic   hit_q;
  idx_t   hit_idx;
  count_t hit_cnt;
  idx_t   hit_rank;
  val_t   hit_val;
  best_t  vic;
  idx_t   vic_idx;
  logic   free_q;
  idx_t   free_idx;

  logic   rsp_valid;
  logic   rsp_found;
  val_t   rsp_value;

  cand_t    cand;
  cmp_res_t res;
  logic     last;
  logic     hit_now;
  logic     accept;
  logic     rsp_load;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;

  assign cand.valid = entry_valid[idx];
  assign cand.key   = entry_key[idx];
  assign cand.cnt   = use_count[idx];
  assign cand.rank  = recency_rank[idx];

  lfct_cmp u_cmp (
    .lookup_key (key_q),
    .cand       (cand),
    .best       (vic),
    .res        (res)
  );

  assign last     = (idx == idx_t'(CAPACITY - 1));
  assign hit_now  = hit_q || res.hit;
  assign accept   = req.valid && req.ready;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp.ready);

  assign req.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.found      = rsp_found;
  assign rsp.read_value = rsp_value;

  always_comb begin
    cap_ext = CMP_W'(capacity);
    cap_eff = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      occ       <= '0;
      rsp_valid <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) entry_valid[i] <= 1'b0;
    end else begin
      if (cfg.valid) capacity <= cfg.data;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (res.hit) hit_q <= 1'b1;
          if (!cand.valid && !free_q) free_q <= 1'b1;
          if (last) begin
            if (hit_now) begin
              state <= S_TOUCH;
            end else if ((cmd_q == CMD_PUT) && (cap_eff != '0)) begin
              state <= (CMP_W'(occ) >= cap_eff) ? S_EVICT : S_INSERT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_TOUCH: begin
          state <= S_DONE;
        end
        S_EVICT: begin
          if (vic.found) begin
            entry_valid[vic_idx] <= 1'b0;
            occ    <= occ - 1'b1;
            free_q <= 1'b1;
          end
          state <= S_INSERT;
        end
        S_INSERT: begin
          if (free_q) begin
            entry_valid[free_idx] <= 1'b1;
            occ <= occ + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload and table contents
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q     <= req.cmd;
          key_q     <= req.lookup_key;
          val_q     <= req.new_value;
          idx       <= '0;
          vic.found <= 1'b0;
        end
      end
      S_SCAN: begin
        idx <= idx_t'(idx + 1'b1);
        if (res.hit) begin
          hit_idx  <= idx;
          hit_cnt  <= cand.cnt;
          hit_rank <= cand.rank;
          hit_val  <= entry_value[idx];
        end
        if (res.better) begin
          vic.found <= 1'b1;
          vic.cnt   <= cand.cnt;
          vic.rank  <= cand.rank;
          vic_idx   <= idx;
        end
        if (!cand.valid && !free_q) free_idx <= idx;
      end
      S_TOUCH: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (entry_valid[i] && (recency_rank[i] < hit_rank))
            recency_rank[i] <= idx_t'(recency_rank[i] + 1'b1);
        end
        recency_rank[hit_idx] <= '0;
        if (hit_cnt != COUNT_MAX) use_count[hit_idx] <= count_t'(hit_cnt + 1'b1);
        if (cmd_q == CMD_PUT) entry_value[hit_idx] <= val_q;
      end
      S_EVICT: begin
        if (vic.found) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (entry_valid[i] && (recency_rank[i] > vic.rank))
              recency_rank[i] <= idx_t'(recency_rank[i] - 1'b1);
          end
          if (!free_q || (vic_idx < free_idx)) free_idx <= vic_idx;
        end
      end
      S_INSERT: begin
        if (free_q) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (entry_valid[i]) recency_rank[i] <= idx_t'(recency_rank[i] + 1'b1);
          end
          entry_key[free_idx]    <= key_q;
          entry_value[free_idx]  <= val_q;
          use_count[free_idx]    <= '0;
          recency_rank[free_idx] <= '0;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          rsp_found <= hit_q;
          rsp_value <= (hit_q && (cmd_q == CMD_GET)) ? hit_val : '1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/lfct_checker.sv */
// Port-level checker for the LFU cache table, bound to the top level.
// Depends on lfu_cache_table_top_macros.svh.
`include "lfu_cache_table_top_macros.svh"

module lfct_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [31:0] read_value
);

  // not ready once a request is taken, checked at the start of the scan and again after it ends
  `LFCT_ASSERT(a_busy_scan, clk, rst, (in_valid && in_ready) |=> !in_ready ##16 !in_ready)

  // a new response only follows a busy cycle
  `LFCT_ASSERT(a_rsp_after_work, clk, rst, $rose(out_valid) |-> $past(!in_ready))

  // miss reports all ones; the design also returns all ones for a put
  `LFCT_ASSERT_MSG(a_miss_value, clk, rst, (out_valid && !found) |-> (read_value == '1),
                   "lfct miss without all-ones value")

  `LFCT_ASSERT_MSG(a_rsp_hold, clk, rst,
                   (out_valid && !out_ready) |=> (out_valid && $stable(found) &&
                                                  $stable(read_value)),
                   "lfct response changed while stalled")

endmodule

bind lfu_cache_table_top lfct_checker u_lfct_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .found      (rsp.found),
  .read_value (rsp.read_value)
);
